>>> sv/backface_cull_meta_tracker_unit_assert.svh
// Assertion macros for the culling tracker checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BACKFACE_CULL_META_TRACKER_UNIT_ASSERT_SVH
`define BACKFACE_CULL_META_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define BFCMT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bfcmt assertion failed");

// next-cycle implication
`define BFCMT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bfcmt assertion failed");

`endif

>>> sv/bfcmt_pkg.sv
// Types and constants for the back-face-culling meta tracker.
// No dependencies; imported by every module of the block.
package bfcmt_pkg;

    typedef enum logic [2:0] {
        ACT_META      = 3'd0,
        ACT_SUBFILE   = 3'd1,
        ACT_DRAW      = 3'd2,
        ACT_OTHER     = 3'd3,
        ACT_NEW_MODEL = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_ON      = 2'd1,
        MODE_OFF     = 2'd2
    } mode_t;

    localparam int unsigned DIAG_W = 10;

    localparam int unsigned DG_INV_UNUSED    = 0;
    localparam int unsigned DG_LATE_NOCERT   = 1;
    localparam int unsigned DG_LATE_FIRST    = 2;
    localparam int unsigned DG_CERT_REPEAT   = 3;
    localparam int unsigned DG_CERT_AFTER_NO = 4;
    localparam int unsigned DG_NO_AFTER_CERT = 5;
    localparam int unsigned DG_NO_REPEAT     = 6;
    localparam int unsigned DG_CLIP_CONFLICT = 7;
    localparam int unsigned DG_WIND_CONFLICT = 8;
    localparam int unsigned DG_META_AFTER_NO = 9;

    localparam int unsigned IN_ITEM_W  = 10;
    localparam int unsigned OUT_ITEM_W = 15;

    typedef struct packed {
        logic    has_invertnext;
        logic    has_ccw;
        logic    has_cw;
        logic    has_noclip;
        logic    has_clip;
        logic    has_nocertify;
        logic    has_certify;
        action_t action;
    } in_item_t;

    typedef struct packed {
        logic [DIAG_W-1:0] diag_mask;
        logic              invert_out;
        logic              ccw_out;
        logic              clip_out;
        mode_t             mode_out;
    } out_item_t;

    typedef struct packed {
        mode_t mode;
        logic  clip_on;
        logic  winding_ccw;
        logic  invert_pending;
        logic  drawing_started;
    } track_state_t;

    localparam track_state_t TRACK_RESET = '{
        mode:            MODE_UNKNOWN,
        clip_on:         1'b0,
        winding_ccw:     1'b1,
        invert_pending:  1'b0,
        drawing_started: 1'b0
    };

    // handoff between the input register and the tracker core
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

>>> sv/bfcmt_in_reg.sv
// Input register stage of the culling tracker.
// Depends on bfcmt_pkg.
module bfcmt_in_reg
    import bfcmt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    input  logic       advance,
    output stage_ctl_t ctl,
    output in_item_t   item
);

    logic     valid_reg, valid_next;
    in_item_t item_reg, item_next;

    always_comb begin
        s_ready    = !valid_reg || advance;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                item_next = s_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign item        = item_reg;

endmodule

>>> sv/bfcmt_core.sv
// Culling state registers and per-line update logic.
// Depends on bfcmt_pkg.
module bfcmt_core
    import bfcmt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  stage_ctl_t ctl,
    input  in_item_t   item,
    output out_item_t  result
);

    track_state_t st_reg, st_next;

    always_comb begin
        track_state_t      s;
        logic [DIAG_W-1:0] d;
        logic              any_kw;

        s      = st_reg;
        d      = '0;
        any_kw = 1'b0;

        result.mode_out   = st_reg.mode;
        result.clip_out   = st_reg.clip_on;
        result.ccw_out    = st_reg.winding_ccw;
        result.invert_out = st_reg.invert_pending;

        case (item.action)
            ACT_SUBFILE, ACT_DRAW: begin
                s.drawing_started = 1'b1;
                if (st_reg.invert_pending) begin
                    if (item.action == ACT_DRAW) begin
                        d[DG_INV_UNUSED] = 1'b1;
                    end
                    s.invert_pending = 1'b0;
                end
            end
            ACT_META: begin
                if (s.invert_pending) begin
                    d[DG_INV_UNUSED] = 1'b1;
                    s.invert_pending = 1'b0;
                end
                if (s.mode == MODE_UNKNOWN) begin
                    if (item.has_nocertify) begin
                        s.mode = MODE_OFF;
                        d[DG_LATE_NOCERT] = s.drawing_started;
                    end else if (s.drawing_started) begin
                        s.mode = MODE_OFF;
                        d[DG_LATE_FIRST] = 1'b1;
                    end else begin
                        s.mode    = MODE_ON;
                        s.clip_on = 1'b1;
                    end
                end else begin
                    if (item.has_certify) begin
                        if (s.mode == MODE_ON) begin
                            d[DG_CERT_REPEAT] = 1'b1;
                        end else begin
                            d[DG_CERT_AFTER_NO] = 1'b1;
                        end
                    end
                    if (item.has_nocertify) begin
                        if (s.mode == MODE_ON) begin
                            d[DG_NO_AFTER_CERT] = 1'b1;
                        end else begin
                            d[DG_NO_REPEAT] = 1'b1;
                        end
                    end
                end
                any_kw = item.has_clip || item.has_noclip || item.has_cw
                      || item.has_ccw || item.has_invertnext;
                if (s.mode == MODE_ON) begin
                    if (item.has_clip) begin
                        if (item.has_noclip) begin
                            d[DG_CLIP_CONFLICT] = 1'b1;
                        end else begin
                            s.clip_on = 1'b1;
                        end
                    end else if (item.has_noclip) begin
                        s.clip_on = 1'b0;
                    end
                    if (item.has_ccw) begin
                        if (item.has_cw) begin
                            d[DG_WIND_CONFLICT] = 1'b1;
                        end else begin
                            s.winding_ccw = 1'b1;
                        end
                    end else if (item.has_cw) begin
                        s.winding_ccw = 1'b0;
                    end
                    if (item.has_invertnext) begin
                        s.invert_pending = 1'b1;
                    end
                end else if (any_kw) begin
                    d[DG_META_AFTER_NO] = 1'b1;
                end
                result.mode_out   = s.mode;
                result.clip_out   = s.clip_on;
                result.ccw_out    = s.winding_ccw;
                result.invert_out = s.invert_pending;
            end
            ACT_NEW_MODEL: begin
                s                 = TRACK_RESET;
                result.mode_out   = TRACK_RESET.mode;
                result.clip_out   = TRACK_RESET.clip_on;
                result.ccw_out    = TRACK_RESET.winding_ccw;
                result.invert_out = TRACK_RESET.invert_pending;
            end
            default: begin
                s = st_reg;
            end
        endcase

        result.diag_mask = d;
        st_next          = s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= TRACK_RESET;
        end else if (ctl.valid && ctl.advance) begin
            st_reg <= st_next;
        end
    end

endmodule

>>> sv/bfcmt_out_reg.sv
// Result register stage of the culling tracker.
// Depends on bfcmt_pkg.
module bfcmt_out_reg
    import bfcmt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  out_item_t result,
    output logic      advance,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg, valid_next;
    out_item_t item_reg, item_next;

    always_comb begin
        advance    = !valid_reg || m_ready;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (advance) begin
            valid_next = in_valid;
            if (in_valid) begin
                item_next = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

>>> sv/backface_cull_meta_tracker_unit.sv
// Top level of the back-face-culling meta tracker: input register, tracker core,
// result register. Depends on bfcmt_pkg, bfcmt_in_reg, bfcmt_core, bfcmt_out_reg.
//
//   channel | dir | tuser       | tdata fields (lsb first)
//   s_      | in  | action[2:0] | certify nocertify clip noclip cw ccw invertnext
//   m_      | out | -           | mode_out[1:0] clip_out ccw_out invert_out diag_mask[9:0]
//
// One transaction per cycle sustained while m_tready stays high; the result is offered
// once the line has passed through the input register and then the result register.
// Culling state updates as a line moves from the input to the result register.
// Reset (aresetn low, synchronous) empties both stages and restores the state.
// A stalled m_ side holds the result; s_tready stays high while a slot is free.
module backface_cull_meta_tracker_unit
    import bfcmt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // action
    input  logic [7:0]  s_tdata,   // has_certify, has_nocertify, has_clip, has_noclip,
                                   // has_cw, has_ccw, has_invertnext
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // mode_out, clip_out, ccw_out, invert_out, diag_mask
);

    stage_ctl_t ctl;
    in_item_t   item;
    out_item_t  result;
    out_item_t  m_item;
    logic       advance;

    bfcmt_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (in_item_t'({s_tdata[6:0], s_tuser})),
        .advance (advance),
        .ctl     (ctl),
        .item    (item)
    );

    bfcmt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .item    (item),
        .result  (result)
    );

    bfcmt_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (ctl.valid),
        .result   (result),
        .advance  (advance),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_item   (m_item)
    );

    assign m_tdata = {{(16 - OUT_ITEM_W){1'b0}}, m_item};

endmodule

>>> sv/bfcmt_checker.sv
// Port-level checker for the culling tracker, bound to the top level.
// Depends on bfcmt_pkg and backface_cull_meta_tracker_unit_assert.svh.
`include "backface_cull_meta_tracker_unit_assert.svh"

module bfcmt_checker
    import bfcmt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic [1:0]        m_mode;
    logic [DIAG_W-1:0] m_diag;

    assign m_mode = m_tdata[1:0];
    assign m_diag = m_tdata[14:5];

    `BFCMT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BFCMT_ASSERT_NOW(a_mode_legal, aclk, aresetn, m_tvalid, m_mode != 2'd3)
    `BFCMT_ASSERT_NOW(a_unknown_quiet, aclk, aresetn, m_tvalid && (m_mode == MODE_UNKNOWN), !m_tdata[4] && (m_diag == '0))
    `BFCMT_ASSERT_NOW(a_conflict_on, aclk, aresetn, m_tvalid && (m_diag[DG_CLIP_CONFLICT] || m_diag[DG_WIND_CONFLICT]), m_mode == MODE_ON)

endmodule

bind backface_cull_meta_tracker_unit bfcmt_checker u_bfcmt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/tb.sv
// Testbench for backface_cull_meta_tracker_unit: a directed table of culling lines,
// then random line sequences, checked against table values or an in-bench state tracker.
// Depends on bfcmt_pkg and the RTL of the block.
module tb;
    import bfcmt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_LINES = 875;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned HOLD_AT = 300;

    localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

    localparam logic [6:0] F_NONE   = 7'h00;
    localparam logic [6:0] F_CERT   = 7'h01;
    localparam logic [6:0] F_NOCERT = 7'h02;
    localparam logic [6:0] F_CLIP   = 7'h04;
    localparam logic [6:0] F_NOCLIP = 7'h08;
    localparam logic [6:0] F_CW     = 7'h10;
    localparam logic [6:0] F_CCW    = 7'h20;
    localparam logic [6:0] F_INV    = 7'h40;
    localparam logic [6:0] F_ALL    = 7'h7f;

    typedef struct {
        in_item_t  line;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser = '0;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    track_state_t trk;
    out_item_t    pending_results[$];
    dir_row_t     dir_rows[$];
    out_item_t    got_res;
    out_item_t    want_res;
    int           fail_count = 0;
    int           results_seen = 0;
    int           cycles = 0;
    bit           calm = 1'b0;
    bit           fresh = 1'b0;

    backface_cull_meta_tracker_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic in_item_t mk(logic [2:0] act, logic [6:0] flags);
        mk = {flags, act};
    endfunction

    function automatic out_item_t res(mode_t m, logic clip, logic ccw, logic inv,
                                      logic [DIAG_W-1:0] d);
        res = '{diag_mask: d, invert_out: inv, ccw_out: ccw, clip_out: clip, mode_out: m};
    endfunction

    // settings a line is given, then the state update it causes; meta and new-model lines report the updated settings
    function automatic out_item_t track_line(in_item_t line);
        out_item_t         o;
        logic [DIAG_W-1:0] d;
        d = '0;
        if (line.action == ACT_SUBFILE || line.action == ACT_DRAW) begin
            o = res(trk.mode, trk.clip_on, trk.winding_ccw, trk.invert_pending, '0);
            trk.drawing_started = 1'b1;
            if (trk.invert_pending) begin
                if (line.action == ACT_DRAW)
                    d[DG_INV_UNUSED] = 1'b1;
                trk.invert_pending = 1'b0;
            end
        end else begin
            if (line.action == ACT_META) begin
                if (trk.invert_pending) begin
                    d[DG_INV_UNUSED] = 1'b1;
                    trk.invert_pending = 1'b0;
                end
                if (trk.mode == MODE_UNKNOWN) begin
                    if (line.has_nocertify) begin
                        trk.mode = MODE_OFF;
                        if (trk.drawing_started)
                            d[DG_LATE_NOCERT] = 1'b1;
                    end else if (trk.drawing_started) begin
                        trk.mode = MODE_OFF;
                        d[DG_LATE_FIRST] = 1'b1;
                    end else begin
                        trk.mode = MODE_ON;
                        trk.clip_on = 1'b1;
                    end
                end else begin
                    if (line.has_certify) begin
                        if (trk.mode == MODE_ON)
                            d[DG_CERT_REPEAT] = 1'b1;
                        else
                            d[DG_CERT_AFTER_NO] = 1'b1;
                    end
                    if (line.has_nocertify) begin
                        if (trk.mode == MODE_ON)
                            d[DG_NO_AFTER_CERT] = 1'b1;
                        else
                            d[DG_NO_REPEAT] = 1'b1;
                    end
                end
                if (trk.mode == MODE_ON) begin
                    if (line.has_clip) begin
                        if (line.has_noclip)
                            d[DG_CLIP_CONFLICT] = 1'b1;
                        else
                            trk.clip_on = 1'b1;
                    end else if (line.has_noclip) begin
                        trk.clip_on = 1'b0;
                    end
                    if (line.has_ccw) begin
                        if (line.has_cw)
                            d[DG_WIND_CONFLICT] = 1'b1;
                        else
                            trk.winding_ccw = 1'b1;
                    end else if (line.has_cw) begin
                        trk.winding_ccw = 1'b0;
                    end
                    if (line.has_invertnext)
                        trk.invert_pending = 1'b1;
                end else if (line.has_clip || line.has_noclip || line.has_cw ||
                             line.has_ccw || line.has_invertnext) begin
                    d[DG_META_AFTER_NO] = 1'b1;
                end
            end else if (line.action == ACT_NEW_MODEL) begin
                trk = TRACK_RESET;
            end
            o = res(trk.mode, trk.clip_on, trk.winding_ccw, trk.invert_pending, '0);
        end
        o.diag_mask = d;
        return o;
    endfunction

    // mostly well-formed models: new model, certify header, then mixed lines
    function automatic in_item_t random_line();
        int unsigned r;
        logic [6:0]  flags;
        r = $urandom_range(99);
        flags = '0;
        flags[0] = ($urandom_range(3) == 0);
        flags[1] = ($urandom_range(5) == 0);
        flags[2] = ($urandom_range(2) == 0);
        flags[3] = ($urandom_range(2) == 0);
        flags[4] = ($urandom_range(2) == 0);
        flags[5] = ($urandom_range(2) == 0);
        flags[6] = ($urandom_range(3) == 0);
        if (fresh && r < 70) begin
            fresh = 1'b0;
            return mk(ACT_META, F_CERT | (flags & ~F_NOCERT));
        end
        fresh = 1'b0;
        if (r < 5) begin
            fresh = 1'b1;
            return mk(ACT_NEW_MODEL, flags);
        end
        if (r < 42)
            return mk(ACT_META, flags);
        if (r < 62)
            return mk(ACT_SUBFILE, flags);
        if (r < 88)
            return mk(ACT_DRAW, flags);
        if (r < 95)
            return mk(ACT_OTHER, flags);
        return mk(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), flags);
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("tb: mismatch in %s at result %0d: got %0d, expected %0d",
                 field, results_seen, got, want);
        fail_count++;
    endtask

    task automatic send_line(in_item_t line, bit typed, out_item_t want);
        out_item_t predicted;
        while (!calm && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= line[2:0];
        s_tdata  <= {1'b0, line[9:3]};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = track_line(line);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = m_tdata[OUT_ITEM_W-1:0];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", int'(got_res), -1);
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.mode_out !== want_res.mode_out)
                    report_mismatch("mode_out", got_res.mode_out, want_res.mode_out);
                if (got_res.clip_out !== want_res.clip_out)
                    report_mismatch("clip_out", got_res.clip_out, want_res.clip_out);
                if (got_res.ccw_out !== want_res.ccw_out)
                    report_mismatch("ccw_out", got_res.ccw_out, want_res.ccw_out);
                if (got_res.invert_out !== want_res.invert_out)
                    report_mismatch("invert_out", got_res.invert_out, want_res.invert_out);
                if (got_res.diag_mask !== want_res.diag_mask)
                    report_mismatch("diag_mask", got_res.diag_mask, want_res.diag_mask);
            end
            results_seen <= results_seen + 1;
        end
    end

    // result side; one long hold-off lets the block fill and back up its input
    initial begin : result_side
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 8);
            end
        end
    end

    initial begin : line_source
        int        sent;
        in_item_t  line;
        out_item_t none;
        none = '0;
        trk = TRACK_RESET;

        dir_rows.push_back('{mk(ACT_OTHER, F_NONE), 1'b1,
                             res(MODE_UNKNOWN, 1'b0, 1'b1, 1'b0, '0)});
        dir_rows.push_back('{mk(ACT_META, F_CERT | F_CLIP | F_NOCLIP), 1'b1,
                             res(MODE_ON, 1'b1, 1'b1, 1'b0, 10'd1 << DG_CLIP_CONFLICT)});
        dir_rows.push_back('{mk(ACT_META, F_CERT | F_CW | F_CCW), 1'b1,
                             res(MODE_ON, 1'b1, 1'b1, 1'b0, (10'd1 << DG_CERT_REPEAT) |
                                                   (10'd1 << DG_WIND_CONFLICT))});
        dir_rows.push_back('{mk(ACT_META, F_NOCLIP | F_CW | F_INV), 1'b0, none});
        dir_rows.push_back('{mk(ACT_DRAW, F_NONE), 1'b0, none});
        dir_rows.push_back('{mk(ACT_META, F_INV), 1'b0, none});
        dir_rows.push_back('{mk(ACT_SUBFILE, F_ALL), 1'b0, none});
        dir_rows.push_back('{mk(ACT_META, F_INV), 1'b0, none});
        dir_rows.push_back('{mk(ACT_META, F_CLIP | F_CCW), 1'b0, none});
        dir_rows.push_back('{mk(ACT_META, F_NOCERT), 1'b0, none});
        dir_rows.push_back('{mk(ACT_NEW_MODEL, F_ALL), 1'b1,
                             res(MODE_UNKNOWN, 1'b0, 1'b1, 1'b0, '0)});
        dir_rows.push_back('{mk(ACT_META, F_CERT | F_NOCERT | F_CLIP), 1'b1,
                             res(MODE_OFF, 1'b0, 1'b1, 1'b0, 10'd1 << DG_META_AFTER_NO)});
        dir_rows.push_back('{mk(ACT_META, F_CERT | F_NOCERT), 1'b1,
                             res(MODE_OFF, 1'b0, 1'b1, 1'b0, (10'd1 << DG_CERT_AFTER_NO) |
                                                    (10'd1 << DG_NO_REPEAT))});
        dir_rows.push_back('{mk(ACT_META, F_ALL), 1'b0, none});
        dir_rows.push_back('{mk(ACT_NEW_MODEL, F_NONE), 1'b1,
                             res(MODE_UNKNOWN, 1'b0, 1'b1, 1'b0, '0)});
        dir_rows.push_back('{mk(ACT_DRAW, F_ALL), 1'b0, none});
        dir_rows.push_back('{mk(ACT_META, F_NOCERT), 1'b1,
                             res(MODE_OFF, 1'b0, 1'b1, 1'b0, 10'd1 << DG_LATE_NOCERT)});
        dir_rows.push_back('{mk(ACT_NEW_MODEL, F_NONE), 1'b0, none});
        dir_rows.push_back('{mk(ACT_SUBFILE, F_NONE), 1'b0, none});
        dir_rows.push_back('{mk(ACT_META, F_NONE), 1'b1,
                             res(MODE_OFF, 1'b0, 1'b1, 1'b0, 10'd1 << DG_LATE_FIRST)});
        dir_rows.push_back('{mk(ACT_NEW_MODEL, F_NONE), 1'b0, none});
        dir_rows.push_back('{mk(ACT_META, F_ALL), 1'b0, none});
        dir_rows.push_back('{mk(ACT_SPARE_LO, F_ALL), 1'b0, none});
        dir_rows.push_back('{mk(ACT_SPARE_MID, F_NONE), 1'b0, none});
        dir_rows.push_back('{mk(ACT_SPARE_HI, F_ALL), 1'b0, none});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_line(dir_rows[i].line, dir_rows[i].typed, dir_rows[i].want);

        fresh = 1'b1;
        sent = 0;
        while (sent < RANDOM_LINES) begin
            if (sent == 400)
                calm <= 1'b1;
            else if (sent == 550)
                calm <= 1'b0;
            line = random_line();
            send_line(line, 1'b0, none);
            sent++;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
